FILE: sv/sle_pkg.sv
// Shared constants, word codes and interface structs for the serial line editor.
// No dependencies; all other files import this package.
package sle_pkg;

  localparam int LINE_DEPTH = 128;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int LEN_W      = 7;

  localparam logic [7:0] CH_DEL = 8'h7F;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_SP  = 8'h20;

  localparam logic KIND_RX   = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic              is_read;
    logic [7:0]        first_ch;
    logic [7:0]        follow_ch;
    logic [1:0]        n_last;
    logic              done;
    logic [LEN_W-1:0]  len;
  } sle_desc_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } sle_mem_req_t;

endpackage

FILE: sv/sle_line_mem.sv
// Line store: one write port, one read port, registered read data.
// Depends on sle_pkg for depth and request struct.
module sle_line_mem (
  input  logic                  clk,
  input  sle_pkg::sle_mem_req_t req,
  output logic [7:0]            rdata
);
  import sle_pkg::*;

  logic [7:0] mem [LINE_DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata_r <= mem[req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: sv/sle_front.sv
// Input stage: decode each word, update the write position, drive the line store.
// Depends on sle_pkg; feeds sle_result_seq through a descriptor register.
module sle_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_kind,
  input  logic [7:0]                   in_rx_byte,
  input  logic [sle_pkg::ADDR_W-1:0]   in_read_index,
  output sle_pkg::sle_mem_req_t        mem_req,
  output sle_pkg::sle_desc_t           desc,
  output logic                         desc_valid,
  input  logic                         desc_ready
);
  import sle_pkg::*;

  logic [ADDR_W-1:0] wp_r, wp_nxt;
  logic              zpend_r, zpend_nxt;
  logic [ADDR_W-1:0] zaddr_r, zaddr_nxt;
  logic              v_r, v_nxt;
  sle_desc_t         desc_r, desc_nxt;
  logic              accept;
  logic [ADDR_W-1:0] wp_inc;

  assign in_ready = !zpend_r && (!v_r || desc_ready);
  assign accept   = in_valid && in_ready;
  assign wp_inc   = wp_r + ADDR_W'(1);

  always_comb begin
    wp_nxt    = wp_r;
    zpend_nxt = 1'b0;
    zaddr_nxt = zaddr_r;
    desc_nxt  = desc_r;
    mem_req   = '0;
    v_nxt     = v_r;
    if (zpend_r) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = zaddr_r;
      mem_req.wdata = 8'h00;
    end
    if (desc_ready) begin
      v_nxt = 1'b0;
    end
    if (accept) begin
      v_nxt              = 1'b1;
      desc_nxt           = '0;
      desc_nxt.first_ch  = in_rx_byte;
      desc_nxt.follow_ch = CH_BS;
      if (in_kind == KIND_READ) begin
        desc_nxt.is_read  = 1'b1;
        desc_nxt.first_ch = 8'h00;
        mem_req.re        = 1'b1;
        mem_req.raddr     = in_read_index;
      end else if (in_rx_byte == CH_CR || in_rx_byte == CH_LF) begin
        desc_nxt.follow_ch = (in_rx_byte == CH_CR) ? CH_LF : CH_CR;
        desc_nxt.n_last    = 2'd1;
        desc_nxt.done      = 1'b1;
        desc_nxt.len       = LEN_W'(wp_r);
        mem_req.we         = 1'b1;
        mem_req.waddr      = wp_r;
        mem_req.wdata      = 8'h00;
        wp_nxt             = '0;
      end else if (in_rx_byte == CH_DEL) begin
        if (wp_r != '0) begin
          desc_nxt.n_last = 2'd3;
          wp_nxt          = wp_r - ADDR_W'(1);
        end
      end else if (in_rx_byte >= CH_SP) begin
        mem_req.we    = 1'b1;
        mem_req.waddr = wp_r;
        mem_req.wdata = in_rx_byte;
        wp_nxt        = wp_inc;
        if (wp_r == ADDR_W'(LINE_DEPTH - 2)) begin
          desc_nxt.done = 1'b1;
          desc_nxt.len  = LEN_W'(wp_inc);
          zpend_nxt     = 1'b1;
          zaddr_nxt     = wp_inc;
          wp_nxt        = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r    <= '0;
      zpend_r <= 1'b0;
      v_r     <= 1'b0;
    end else begin
      wp_r    <= wp_nxt;
      zpend_r <= zpend_nxt;
      v_r     <= v_nxt;
    end
    zaddr_r <= zaddr_nxt;
    desc_r  <= desc_nxt;
  end

  assign desc       = desc_r;
  assign desc_valid = v_r;

endmodule

FILE: sv/sle_result_seq.sv
// Result sequencer: expands one descriptor into one to four output words.
// Depends on sle_pkg; takes read data straight from the line store.
module sle_result_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  sle_pkg::sle_desc_t         desc,
  input  logic                       desc_valid,
  output logic                       desc_ready,
  input  logic [7:0]                 rdata,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_echo_byte,
  output logic                       out_echo_valid,
  output logic [7:0]                 out_read_byte,
  output logic                       out_line_done,
  output logic [sle_pkg::LEN_W-1:0]  out_line_length,
  output logic                       out_last
);
  import sle_pkg::*;

  sle_desc_t  cur_r;
  logic [7:0] rb_r;
  logic [1:0] idx_r;
  logic       busy_r;
  logic       is_last;
  logic       fire;
  logic       finish;

  assign is_last    = (idx_r == cur_r.n_last);
  assign fire       = busy_r && out_ready;
  assign finish     = fire && is_last;
  assign desc_ready = !busy_r || finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (desc_valid && desc_ready) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (finish) begin
      busy_r <= 1'b0;
    end else if (fire) begin
      idx_r <= idx_r + 2'd1;
    end
    if (desc_valid && desc_ready) begin
      cur_r <= desc;
      rb_r  <= rdata;
    end
  end

  always_comb begin
    unique case (idx_r)
      2'd0:    out_echo_byte = cur_r.first_ch;
      2'd2:    out_echo_byte = CH_SP;
      default: out_echo_byte = cur_r.follow_ch;
    endcase
    if (cur_r.is_read) begin
      out_echo_byte = 8'h00;
    end
  end

  assign out_valid       = busy_r;
  assign out_echo_valid  = !cur_r.is_read;
  assign out_read_byte   = cur_r.is_read ? rb_r : 8'h00;
  assign out_line_done   = cur_r.done && is_last;
  assign out_line_length = (cur_r.done && is_last) ? cur_r.len : '0;
  assign out_last        = is_last;

endmodule

FILE: sv/serial_line_editor.sv
// Serial line editor top level: input stage, line store and result sequencer.
// Depends on sle_pkg, sle_front, sle_line_mem and sle_result_seq.
//
//   channel  | handshake              | payload
//   in_      | in_valid / in_ready    | kind, rx_byte, read_index
//   out_     | out_valid / out_ready  | echo_byte, echo_valid, read_byte,
//            |                        | line_done, line_length, last
//
// A word is taken every cycle while the sequencer keeps up; its results pass
// the descriptor register, then the sequencer, which emits one result per cycle
// while out_ready is high, one to four per word, taking a new word at the last.
// A byte that fills the line holds in_ready low for the terminator write.
// Reset clears the write position and all handshake state; the store is not
// cleared. Output stalls back up through the descriptor register to in_ready.
module serial_line_editor (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       in_kind,
  input  logic [7:0]                 in_rx_byte,
  input  logic [sle_pkg::ADDR_W-1:0] in_read_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_echo_byte,
  output logic                       out_echo_valid,
  output logic [7:0]                 out_read_byte,
  output logic                       out_line_done,
  output logic [sle_pkg::LEN_W-1:0]  out_line_length,
  output logic                       out_last
);
  import sle_pkg::*;

  sle_mem_req_t mem_req;
  sle_desc_t    desc;
  logic         desc_valid;
  logic         desc_ready;
  logic [7:0]   rdata;

  sle_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_rx_byte    (in_rx_byte),
    .in_read_index (in_read_index),
    .mem_req       (mem_req),
    .desc          (desc),
    .desc_valid    (desc_valid),
    .desc_ready    (desc_ready)
  );

  sle_line_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  sle_result_seq u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .desc            (desc),
    .desc_valid      (desc_valid),
    .desc_ready      (desc_ready),
    .rdata           (rdata),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_echo_byte   (out_echo_byte),
    .out_echo_valid  (out_echo_valid),
    .out_read_byte   (out_read_byte),
    .out_line_done   (out_line_done),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

endmodule

FILE: sim/sle_checker.sv
// Checker for the serial line editor: watches both channels, predicts the result words
// of every accepted input word and compares them field by field in order.
// Depends on sle_pkg.
module sle_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  logic                            in_kind,
  input  logic [7:0]                      in_rx_byte,
  input  logic [sle_pkg::ADDR_W-1:0]      in_read_index,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  logic [7:0]                      out_echo_byte,
  input  logic                            out_echo_valid,
  input  logic [7:0]                      out_read_byte,
  input  logic                            out_line_done,
  input  logic [sle_pkg::LEN_W-1:0]       out_line_length,
  input  logic                            out_last,
  output int                              mismatch_count,
  output int                              pending_count,
  output logic [sle_pkg::LINE_DEPTH-1:0]  store_written
);
  timeunit 1ns;
  timeprecision 1ps;
  import sle_pkg::*;

  typedef struct packed {
    logic [7:0]       echo_byte;
    logic             echo_valid;
    logic [7:0]       read_byte;
    logic             line_done;
    logic [LEN_W-1:0] line_length;
    logic             last;
  } editor_result_t;

  editor_result_t        expected_results[$];
  logic [7:0]            line_buf [LINE_DEPTH];
  logic [LINE_DEPTH-1:0] written_map = '0;
  int                    line_pos = 0;
  int                    result_number = 0;

  initial begin
    mismatch_count = 0;
    pending_count  = 0;
    store_written  = '0;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result %0d: %s", $realtime, result_number, msg);
    mismatch_count++;
  endtask

  function automatic editor_result_t echo_result(input logic [7:0] ch);
    editor_result_t r;
    r            = '0;
    r.echo_byte  = ch;
    r.echo_valid = 1'b1;
    return r;
  endfunction

  task automatic predict_echo(input logic kind, input logic [7:0] ch,
                              input logic [ADDR_W-1:0] idx);
    editor_result_t burst[4];
    int             n;
    logic           ends_line;
    n         = 0;
    ends_line = 1'b0;
    if (kind == KIND_READ) begin
      burst[0]           = '0;
      burst[0].read_byte = line_buf[idx];
      n                  = 1;
    end else begin
      burst[n++] = echo_result(ch);
      if (ch == CH_CR || ch == CH_LF) begin
        burst[n++] = echo_result(ch == CH_CR ? CH_LF : CH_CR);
        ends_line  = 1'b1;
      end else if (ch == CH_DEL) begin
        if (line_pos > 0) begin
          line_pos--;
          burst[n++] = echo_result(CH_BS);
          burst[n++] = echo_result(CH_SP);
          burst[n++] = echo_result(CH_BS);
        end
      end else if (ch >= CH_SP) begin
        line_buf[line_pos]    = ch;
        written_map[line_pos] = 1'b1;
        line_pos++;
        ends_line = (line_pos >= LINE_DEPTH - 1);
      end
      if (ends_line) begin
        line_buf[line_pos]        = 8'h00;
        written_map[line_pos]     = 1'b1;
        burst[n-1].line_done      = 1'b1;
        burst[n-1].line_length    = LEN_W'(line_pos);
        line_pos                  = 0;
      end
    end
    burst[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_results.push_back(burst[i]);
  endtask

  task automatic check_result(input editor_result_t got, input editor_result_t want);
    if (got.echo_byte !== want.echo_byte)
      report_mismatch($sformatf("echo_byte %h, expected %h", got.echo_byte, want.echo_byte));
    if (got.echo_valid !== want.echo_valid)
      report_mismatch($sformatf("echo_valid %b, expected %b", got.echo_valid,
                                want.echo_valid));
    if (got.read_byte !== want.read_byte)
      report_mismatch($sformatf("read_byte %h, expected %h", got.read_byte, want.read_byte));
    if (got.line_done !== want.line_done)
      report_mismatch($sformatf("line_done %b, expected %b", got.line_done, want.line_done));
    if (got.line_length !== want.line_length)
      report_mismatch($sformatf("line_length %0d, expected %0d", got.line_length,
                                want.line_length));
    if (got.last !== want.last)
      report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
  endtask

  always @(posedge clk) begin
    editor_result_t got;
    if (!rst_n) begin
      line_pos = 0;
      expected_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_echo_byte, out_echo_valid, out_read_byte, out_line_done,
                out_line_length, out_last};
        if (expected_results.size() == 0)
          report_mismatch($sformatf("word with nothing expected, echo_byte %h", got.echo_byte));
        else
          check_result(got, expected_results.pop_front());
        result_number++;
      end
      if (in_valid && in_ready) predict_echo(in_kind, in_rx_byte, in_read_index);
    end
    pending_count <= expected_results.size();
    store_written <= written_map;
  end

endmodule

FILE: sim/testbench.sv
// Top of the serial line editor testbench: clock, reset, input and output stimulus
// with idle phases, watchdog and verdict. Depends on sle_pkg, serial_line_editor
// and sle_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sle_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_WORDS    = 12;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_kind = KIND_RX;
  logic [7:0]            in_rx_byte = 8'h00;
  logic [ADDR_W-1:0]     in_read_index = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_echo_byte;
  logic                  out_echo_valid;
  logic [7:0]            out_read_byte;
  logic                  out_line_done;
  logic [LEN_W-1:0]      out_line_length;
  logic                  out_last;

  int                    mismatch_count;
  int                    pending_count;
  logic [LINE_DEPTH-1:0] store_written;

  int                    tx_idle_pct = 32;
  int                    rx_idle_pct = 55;
  int                    words_sent = 0;
  int                    stuck_cycles = 0;

  serial_line_editor dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_rx_byte      (in_rx_byte),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_echo_byte   (out_echo_byte),
    .out_echo_valid  (out_echo_valid),
    .out_read_byte   (out_read_byte),
    .out_line_done   (out_line_done),
    .out_line_length (out_line_length),
    .out_last        (out_last)
  );

  sle_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_rx_byte      (in_rx_byte),
    .in_read_index   (in_read_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_echo_byte   (out_echo_byte),
    .out_echo_valid  (out_echo_valid),
    .out_read_byte   (out_read_byte),
    .out_line_done   (out_line_done),
    .out_line_length (out_line_length),
    .out_last        (out_last),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count),
    .store_written   (store_written)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_word(input logic kind, input logic [7:0] ch,
                           input logic [ADDR_W-1:0] idx);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_rx_byte    <= ch;
    in_read_index <= idx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] ch);
    send_word(KIND_RX, ch, ADDR_W'($urandom));
  endtask

  task automatic send_read(input logic [ADDR_W-1:0] idx);
    send_word(KIND_READ, 8'($urandom), idx);
  endtask

  function automatic logic [7:0] printable_byte();
    logic [7:0] ch;
    ch = 8'($urandom_range(32, 255));
    return (ch == CH_DEL) ? 8'h7E : ch;
  endfunction

  // Only entries that the store already holds are read.
  function automatic int pick_read_index();
    int start;
    int slot;
    start = $urandom_range(LINE_DEPTH - 1);
    for (int j = 0; j < LINE_DEPTH; j++) begin
      slot = (start + j) % LINE_DEPTH;
      if (store_written[slot]) return slot;
    end
    return -1;
  endfunction

  task automatic send_random_line();
    int         len;
    int         choice;
    int         idx;
    logic [7:0] ch;
    len = $urandom_range(0, 14);
    repeat (len) begin
      choice = $urandom_range(99);
      idx    = pick_read_index();
      if (choice < 14 && idx >= 0) begin
        send_read(ADDR_W'(idx));
      end else if (choice < 24) begin
        send_byte(CH_DEL);
      end else if (choice < 31) begin
        ch = 8'($urandom_range(0, 31));
        send_byte(ch);
      end else begin
        send_byte(printable_byte());
      end
    end
    choice = $urandom_range(99);
    if (choice < 45) send_byte(CH_CR);
    else if (choice < 90) send_byte(CH_LF);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    int fill_pos;
    int phase_start;
    bit del_done;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_byte(8'h41);
    send_byte(CH_SP);
    send_byte(8'hFF);
    send_byte(8'h80);
    send_byte(8'h7E);
    send_read(ADDR_W'(4));
    send_read(ADDR_W'(0));
    send_byte(CH_DEL);
    send_byte(8'h00);
    send_byte(8'h1F);
    send_byte(CH_BS);
    send_byte(CH_CR);
    send_read(ADDR_W'(4));
    send_byte(CH_DEL);
    send_byte(CH_LF);
    send_read(ADDR_W'(0));
    send_byte(8'h78);
    send_byte(CH_DEL);
    send_byte(CH_DEL);
    send_byte(8'h55);
    send_byte(CH_LF);
    send_read(ADDR_W'(1));
    send_read(ADDR_W'(2));

    // fill one line to the limit, with one rubout along the way
    fill_pos = 0;
    del_done = 1'b0;
    while (fill_pos < LINE_DEPTH - 1) begin
      if (fill_pos == 70 && !del_done) begin
        send_byte(CH_DEL);
        fill_pos--;
        del_done = 1'b1;
      end else begin
        send_byte(printable_byte());
        fill_pos++;
      end
    end
    send_read(ADDR_W'(LINE_DEPTH - 1));
    send_read(ADDR_W'(LINE_DEPTH - 2));
    drain_results();

    for (int phase = 0; phase < 3; phase++) begin
      tx_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 55 : 0;
      rx_idle_pct = (phase == 0) ? 55 : (phase == 1) ? 32 : 0;
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) send_random_line();
      drain_results();
    end

    repeat (12) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: serial_line_editor.f
sv/sle_pkg.sv
sv/sle_line_mem.sv
sv/sle_front.sv
sv/sle_result_seq.sv
sv/serial_line_editor.sv
sim/sle_checker.sv
sim/testbench.sv
